### rtl/fastcgi_record_deframer_defines.svh
// Assertion macros used by the deframer parser RTL.
`ifndef FASTCGI_RECORD_DEFRAMER_DEFINES_SVH
`define FASTCGI_RECORD_DEFRAMER_DEFINES_SVH

// Same-cycle property, clocked on clk_i, off during reset.
`define FCRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Next-cycle implication.
`define FCRD_ASSERT_NEXT(lbl, pre, post, msg) \
  `FCRD_ASSERT(lbl, (pre) |=> (post), msg)

`endif

### rtl/fcrd_pkg.sv
// Shared constants and types for the FastCGI record deframer.
`timescale 1ns / 1ps
package fcrd_pkg;

  localparam int BUFFER_BYTES = 4096;   // 8 .. 65536
  localparam int HDR_BYTES    = 8;
  localparam int HDR_IDX_W    = $clog2(HDR_BYTES);
  localparam int OFF_W        = 17;     // content + padding offset

  typedef enum logic [HDR_IDX_W-1:0] {
    HDR_VER     = 3'd0,
    HDR_TYPE    = 3'd1,
    HDR_REQ_HI  = 3'd2,
    HDR_REQ_LO  = 3'd3,
    HDR_LEN_HI  = 3'd4,
    HDR_LEN_LO  = 3'd5,
    HDR_PAD     = 3'd6,
    HDR_RSV     = 3'd7
  } hdr_idx_e;

  typedef struct packed {
    logic             data_valid;
    logic [7:0]       payload_byte;
    logic [OFF_W-1:0] body_offset;
    logic             is_padding;
    logic             kept;
    logic             last;
    logic [7:0]       version;
    logic [7:0]       record_type;
    logic [15:0]      request_id;
    logic [15:0]      content_length;
    logic [7:0]       padding_length;
    logic [7:0]       reserved_byte;
  } res_t;

endpackage

### rtl/fcrd_parser.sv
// Header capture, body counter and per-word result logic.
`timescale 1ns / 1ps
`include "fastcgi_record_deframer_defines.svh"
module fcrd_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          acc_i,
  input  logic [7:0]    data_i,
  output logic          res_vld_o,
  output fcrd_pkg::res_t res_o
);
  import fcrd_pkg::*;

  localparam logic [OFF_W-1:0] BUF_LIM = OFF_W'(BUFFER_BYTES);

  logic             in_body_q, in_body_d;
  logic [OFF_W-1:0] pos_q, pos_d;
  logic [7:0]       ver_q, ver_d, typ_q, typ_d, pad_q, pad_d, rsv_q, rsv_d;
  logic [15:0]      req_q, req_d, len_q, len_d;

  logic [OFF_W-1:0] total;
  logic [OFF_W:0]   pos_inc;
  hdr_idx_e         idx;
  logic             fin;

  assign total   = {1'b0, len_q} + {{(OFF_W-8){1'b0}}, pad_q};
  assign pos_inc = {1'b0, pos_q} + {{OFF_W{1'b0}}, 1'b1};
  assign idx     = hdr_idx_e'(pos_q[HDR_IDX_W-1:0]);
  assign fin     = pos_inc >= {1'b0, total};

  always_comb begin
    in_body_d = in_body_q;
    pos_d     = pos_q;
    ver_d     = ver_q;
    typ_d     = typ_q;
    req_d     = req_q;
    len_d     = len_q;
    pad_d     = pad_q;
    rsv_d     = rsv_q;
    res_vld_o = 1'b0;

    res_o.data_valid     = 1'b1;
    res_o.payload_byte   = data_i;
    res_o.body_offset    = pos_q;
    res_o.is_padding     = pos_q >= {1'b0, len_q};
    res_o.kept           = pos_q < BUF_LIM;
    res_o.last           = fin;
    res_o.version        = ver_q;
    res_o.record_type    = typ_q;
    res_o.request_id     = req_q;
    res_o.content_length = len_q;
    res_o.padding_length = pad_q;
    res_o.reserved_byte  = rsv_q;

    if (acc_i) begin
      if (!in_body_q) begin
        case (idx)
          HDR_VER:    ver_d = data_i;
          HDR_TYPE:   typ_d = data_i;
          HDR_REQ_HI: req_d = {data_i, req_q[7:0]};
          HDR_REQ_LO: req_d = {req_q[15:8], data_i};
          HDR_LEN_HI: len_d = {data_i, len_q[7:0]};
          HDR_LEN_LO: len_d = {len_q[15:8], data_i};
          HDR_PAD:    pad_d = data_i;
          default:    rsv_d = data_i;
        endcase
        if (idx != HDR_RSV) begin
          pos_d = OFF_W'(pos_q[HDR_IDX_W-1:0]) + OFF_W'(1);
        end else begin
          pos_d = '0;
          if (total == '0) begin
            // empty record: one marker word carrying the captured header plus byte 7, then the header clears
            res_vld_o            = 1'b1;
            res_o.data_valid     = 1'b0;
            res_o.payload_byte   = '0;
            res_o.body_offset    = '0;
            res_o.is_padding     = 1'b0;
            res_o.kept           = 1'b0;
            res_o.last           = 1'b1;
            res_o.reserved_byte  = data_i;
            ver_d = '0; typ_d = '0; req_d = '0;
            len_d = '0; pad_d = '0; rsv_d = '0;
          end else begin
            in_body_d = 1'b1;
          end
        end
      end else begin
        res_vld_o = 1'b1;
        if (fin) begin
          in_body_d = 1'b0;
          pos_d     = '0;
          ver_d = '0; typ_d = '0; req_d = '0;
          len_d = '0; pad_d = '0; rsv_d = '0;
        end else begin
          pos_d = pos_inc[OFF_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_body_q <= 1'b0;
      pos_q     <= '0;
      ver_q     <= '0;
      typ_q     <= '0;
      req_q     <= '0;
      len_q     <= '0;
      pad_q     <= '0;
      rsv_q     <= '0;
    end else begin
      in_body_q <= in_body_d;
      pos_q     <= pos_d;
      ver_q     <= ver_d;
      typ_q     <= typ_d;
      req_q     <= req_d;
      len_q     <= len_d;
      pad_q     <= pad_d;
      rsv_q     <= rsv_d;
    end
  end

  `FCRD_ASSERT(a_body_word_out, acc_i && in_body_q |-> res_vld_o,
               "body byte accepted without a result")
  `FCRD_ASSERT_NEXT(a_last_rewinds, res_vld_o && res_o.last,
                    !in_body_q && pos_q == '0, "record end did not rewind")
  `FCRD_ASSERT(a_hdr_pos_range, !in_body_q |-> pos_q < OFF_W'(HDR_BYTES),
               "header index out of range")
  `FCRD_ASSERT(a_empty_is_last, res_vld_o && !res_o.data_valid |-> res_o.last,
               "empty-record marker without last")

endmodule

### rtl/fcrd_out_reg.sv
// Result register between the parser and the output channel.
`timescale 1ns / 1ps
module fcrd_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           res_vld_i,
  input  fcrd_pkg::res_t res_i,
  output logic           can_take_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output fcrd_pkg::res_t out_o
);
  import fcrd_pkg::*;

  logic vld_q, vld_d;
  res_t res_q;

  // room when empty or the held word leaves this cycle
  assign can_take_o  = !vld_q || !out_stall_i;
  assign vld_d       = can_take_o ? res_vld_i : vld_q;
  assign out_valid_o = vld_q;
  assign out_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_take_o && res_vld_i) begin
      res_q <= res_i;
    end
  end

endmodule

### rtl/fastcgi_record_deframer.sv
// Top level of the FastCGI record deframer.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-----------------------------
//   in      | input     | in_valid_i / in_stall_o  | data_byte_i
//   out     | output    | out_valid_o / out_stall_i| data_valid_o .. reserved_byte_o
//
// One stream byte per cycle unless a held word meets out_stall_i high. A body
// word appears at the outputs in the cycle after its byte is accepted (the
// result register is the only stage). Header tracker and body counter update
// per byte, so words follow back to back. Header bytes 0..6 give no output word.
// rst_ni is asynchronous, active low; it clears the header and the counter.
// in_stall_o rises only while a word is held and out_stall_i is high.
`timescale 1ns / 1ps
module fastcgi_record_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        data_valid_o,
  output logic [7:0]  payload_byte_o,
  output logic [16:0] body_offset_o,
  output logic        is_padding_o,
  output logic        kept_o,
  output logic        last_o,
  output logic [7:0]  version_o,
  output logic [7:0]  record_type_o,
  output logic [15:0] request_id_o,
  output logic [15:0] content_length_o,
  output logic [7:0]  padding_length_o,
  output logic [7:0]  reserved_byte_o
);
  import fcrd_pkg::*;

  logic acc;
  logic res_vld;
  logic can_take;
  res_t res;
  res_t out_res;

  // a byte is taken whenever the result register has room
  assign in_stall_o = !can_take;
  assign acc        = in_valid_i && can_take;

  fcrd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .data_i    (data_byte_i),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  fcrd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_vld_i   (res_vld),
    .res_i       (res),
    .can_take_o  (can_take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_res)
  );

  assign data_valid_o     = out_res.data_valid;
  assign payload_byte_o   = out_res.payload_byte;
  assign body_offset_o    = out_res.body_offset;
  assign is_padding_o     = out_res.is_padding;
  assign kept_o           = out_res.kept;
  assign last_o           = out_res.last;
  assign version_o        = out_res.version;
  assign record_type_o    = out_res.record_type;
  assign request_id_o     = out_res.request_id;
  assign content_length_o = out_res.content_length;
  assign padding_length_o = out_res.padding_length;
  assign reserved_byte_o  = out_res.reserved_byte;

endmodule

### sim/tb_fastcgi_record_deframer.sv
// Self-checking testbench for the FastCGI record deframer.
`timescale 1ns / 1ps
module tb_fastcgi_record_deframer;
  import fcrd_pkg::*;

  // Cycles with no word moving on either side before the run is called hung.
  // Legal quiet stretches are a sender gap plus a receiver stall.
  localparam int HANG_LIMIT = 4000;
  // Quiet cycles after the last word, to catch stray output words.
  localparam int TAIL_CYCLES = 16;

  // Predicts the words the deframer emits and checks the ones it does emit.
  class record_word_check;
    // Parser state, mirrors the block: header tracker plus body counter.
    bit        in_body;
    bit [16:0] pos;
    bit [7:0]  cur_ver, cur_type, cur_pad, cur_rsv;
    bit [15:0] cur_req, cur_len;
    res_t      pending_words[$];
    int        errors;

    function new();
      in_body = 1'b0;
      pos     = '0;
      errors  = 0;
      clear_header();
    endfunction

    function void clear_header();
      cur_ver  = '0;
      cur_type = '0;
      cur_req  = '0;
      cur_len  = '0;
      cur_pad  = '0;
      cur_rsv  = '0;
    endfunction

    function res_t header_word();
      res_t w;
      w = '0;
      w.version        = cur_ver;
      w.record_type    = cur_type;
      w.request_id     = cur_req;
      w.content_length = cur_len;
      w.padding_length = cur_pad;
      w.reserved_byte  = cur_rsv;
      return w;
    endfunction

    // One accepted stream byte; queues the word it causes, if any.
    function void take_byte(logic [7:0] b);
      res_t        w;
      int unsigned body_len;
      if (!in_body) begin
        case (hdr_idx_e'(pos[2:0]))
          HDR_VER:    cur_ver  = b;
          HDR_TYPE:   cur_type = b;
          HDR_REQ_HI: cur_req[15:8] = b;
          HDR_REQ_LO: cur_req[7:0]  = b;
          HDR_LEN_HI: cur_len[15:8] = b;
          HDR_LEN_LO: cur_len[7:0]  = b;
          HDR_PAD:    cur_pad  = b;
          default:    cur_rsv  = b;
        endcase
        if (pos[2:0] != 3'(HDR_BYTES - 1)) begin
          pos = {14'd0, pos[2:0] + 3'd1};
          return;
        end
        pos     = '0;
        in_body = 1'b1;
        // empty record: a single marker word with no data
        if (cur_len == 0 && cur_pad == 0) begin
          w      = header_word();
          w.last = 1'b1;
          pending_words.push_back(w);
          in_body = 1'b0;
          clear_header();
        end
        return;
      end
      body_len = int'(cur_len) + int'(cur_pad);
      w              = header_word();
      w.data_valid   = 1'b1;
      w.payload_byte = b;
      w.body_offset  = pos;
      w.is_padding   = (int'(pos) >= int'(cur_len));
      w.kept         = (int'(pos) < BUFFER_BYTES);
      w.last         = (int'(pos) + 1 >= body_len);
      pending_words.push_back(w);
      if (w.last) begin
        pos     = '0;
        in_body = 1'b0;
        clear_header();
      end else begin
        pos = pos + 17'd1;
      end
    endfunction

    function void diff(string name, logic [16:0] want, logic [16:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void match_word(res_t got);
      res_t want;
      if (pending_words.size() == 0) begin
        $error("output word with nothing pending: offset %0h byte %0h",
               got.body_offset, got.payload_byte);
        errors++;
        return;
      end
      want = pending_words.pop_front();
      diff("data_valid",     17'(want.data_valid),     17'(got.data_valid));
      diff("payload_byte",   17'(want.payload_byte),   17'(got.payload_byte));
      diff("body_offset",    want.body_offset,         got.body_offset);
      diff("is_padding",     17'(want.is_padding),     17'(got.is_padding));
      diff("kept",           17'(want.kept),           17'(got.kept));
      diff("last",           17'(want.last),           17'(got.last));
      diff("version",        17'(want.version),        17'(got.version));
      diff("record_type",    17'(want.record_type),    17'(got.record_type));
      diff("request_id",     17'(want.request_id),     17'(got.request_id));
      diff("content_length", 17'(want.content_length), 17'(got.content_length));
      diff("padding_length", 17'(want.padding_length), 17'(got.padding_length));
      diff("reserved_byte",  17'(want.reserved_byte),  17'(got.reserved_byte));
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        data_valid_o;
  logic [7:0]  payload_byte_o;
  logic [16:0] body_offset_o;
  logic        is_padding_o;
  logic        kept_o;
  logic        last_o;
  logic [7:0]  version_o;
  logic [7:0]  record_type_o;
  logic [15:0] request_id_o;
  logic [15:0] content_length_o;
  logic [7:0]  padding_length_o;
  logic [7:0]  reserved_byte_o;

  record_word_check scb = new();
  bit   idle_on    = 1'b1;   // both sides draw random gaps while set
  int   bytes_sent = 0;
  res_t seen;

  fastcgi_record_deframer u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .data_valid_o     (data_valid_o),
    .payload_byte_o   (payload_byte_o),
    .body_offset_o    (body_offset_o),
    .is_padding_o     (is_padding_o),
    .kept_o           (kept_o),
    .last_o           (last_o),
    .version_o        (version_o),
    .record_type_o    (record_type_o),
    .request_id_o     (request_id_o),
    .content_length_o (content_length_o),
    .padding_length_o (padding_length_o),
    .reserved_byte_o  (reserved_byte_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Handshakes are judged at the falling edge: every input is driven at the
  // rising edge, so the values seen here are what the next rising edge uses.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.data_valid     = data_valid_o;
      seen.payload_byte   = payload_byte_o;
      seen.body_offset    = body_offset_o;
      seen.is_padding     = is_padding_o;
      seen.kept           = kept_o;
      seen.last           = last_o;
      seen.version        = version_o;
      seen.record_type    = record_type_o;
      seen.request_id     = request_id_o;
      seen.content_length = content_length_o;
      seen.padding_length = padding_length_o;
      seen.reserved_byte  = reserved_byte_o;
      scb.match_word(seen);
    end
  end

  // Receiver: holds stall for a random count of cycles per word, then takes it.
  initial begin
    int  hold;
    bit  taken;
    @(posedge rst_ni);
    forever begin
      hold = idle_on ? $urandom_range(0, 15) : 0;
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do begin
        @(negedge clk_i);
        taken = out_valid_o;
        @(posedge clk_i);
      end while (!taken);
    end
  end

  // Hang detector: counts cycles in which no word moves on either side.
  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < HANG_LIMIT) begin
      @(negedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_fastcgi_record_deframer: done, errors");
    $finish;
  end

  // One stream word: optional random gap, then hold until accepted.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    bit acc;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do begin
      @(negedge clk_i);
      acc = !in_stall_o;
      @(posedge clk_i);
    end while (!acc);
    scb.take_byte(b);
    bytes_sent++;
  endtask

  // Header then body; fill < 0 gives random body bytes, else a constant.
  task automatic send_record(input logic [7:0] ver, input logic [7:0] rtype,
                             input logic [15:0] req, input logic [15:0] clen,
                             input logic [7:0] plen, input logic [7:0] rsv,
                             input int fill);
    int body_len;
    body_len = int'(clen) + int'(plen);
    send_byte(ver);
    send_byte(rtype);
    send_byte(req[15:8]);
    send_byte(req[7:0]);
    send_byte(clen[15:8]);
    send_byte(clen[7:0]);
    send_byte(plen);
    send_byte(rsv);
    for (int i = 0; i < body_len; i++)
      send_byte((fill < 0) ? 8'($urandom) : 8'(fill));
  endtask

  // Mostly short records with random header content; now and then a longer
  // body or a wild padding count. A few runs go without any idling.
  task automatic send_random_record();
    logic [15:0] clen;
    logic [7:0]  plen;
    logic [7:0]  ver;
    int          pick;
    pick = $urandom_range(0, 9);
    if (pick < 7)      clen = 16'($urandom_range(0, 15));
    else if (pick < 9) clen = 16'($urandom_range(0, 255));
    else               clen = 16'($urandom_range(256, 511));
    pick = $urandom_range(0, 9);
    if (pick < 3)      plen = 8'd0;
    else if (pick < 9) plen = 8'($urandom_range(1, 7));
    else               plen = 8'($urandom);
    ver = ($urandom_range(0, 3) != 0) ? 8'd1 : 8'($urandom);
    idle_on = ($urandom_range(0, 4) != 0);
    send_record(ver, 8'($urandom), 16'($urandom), clen, plen, 8'($urandom), -1);
  endtask

  // Sender stops and waits until every pending word has come out.
  task automatic drain_outputs();
    in_valid_i <= 1'b0;
    while (scb.pending_words.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int goal;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty record with all-ones version, type, id and reserved byte,
    // one content byte of 0xFF, one padding byte of 0x00.
    send_record(8'hFF, 8'hFF, 16'hFFFF, 16'd0, 8'd0, 8'hFF, -1);
    send_record(8'h00, 8'h00, 16'h0000, 16'd1, 8'd0, 8'h00, 8'hFF);
    send_record(8'h01, 8'h00, 16'h0001, 16'd0, 8'd1, 8'h00, 8'h00);
    drain_outputs();

    // Random records; a full pause whenever the byte count lands in a window midway.
    goal = bytes_sent + 650;
    while (bytes_sent < goal) begin
      send_random_record();
      if (bytes_sent >= goal - 350 && bytes_sent < goal - 300)
        drain_outputs();
    end

    // Mostly short random records after, to see the header cleared.
    repeat (4) send_random_record();

    drain_outputs();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (scb.errors == 0 && scb.pending_words.size() == 0) begin
      $display("tb_fastcgi_record_deframer: done, clean");
    end else begin
      $display("tb_fastcgi_record_deframer: done, errors");
    end
    $finish;
  end

endmodule
